/* rtl/cau_pkg.sv */
package cau_pkg;

    localparam int FIELD_W = 32;
    localparam int CMD_W   = 2;
    localparam int ST_W    = 2;

    localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 2'd3;

    localparam logic [ST_W-1:0] ST_OK  = 2'd0;
    localparam logic [ST_W-1:0] ST_DZ  = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT = 2'd2;

    // per-item control carried down the divider chain; bit 0 = real lane, bit 1 = imag lane
    typedef struct packed {
        logic            valid;
        logic            is_div;
        logic [1:0]      neg;
        logic [1:0]      over;
        logic [ST_W-1:0] status;
    } ctl_t;

endpackage

/* rtl/cau_front.sv */
module cau_front #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [cau_pkg::CMD_W-1:0]              cmd_i,
    input  logic [DATA_WIDTH-1:0]                  a_re_i,
    input  logic [DATA_WIDTH-1:0]                  a_im_i,
    input  logic [DATA_WIDTH-1:0]                  b_re_i,
    input  logic [DATA_WIDTH-1:0]                  b_im_i,
    output cau_pkg::ctl_t                          ctl_o,
    output logic [2*DATA_WIDTH-1:0]                den_o,
    output logic [1:0][2*DATA_WIDTH-1:0]           rem_o,
    output logic [1:0][DATA_WIDTH-1:0]             lo_o,
    output logic [1:0][DATA_WIDTH-1:0]             q_o
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int NW = 2 * W + FRAC_BITS;
    localparam logic signed [SW-1:0] SMAX = {{(W + 2){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {{(W + 2){1'b1}}, {(W - 1){1'b0}}};

    // stage 1: products and add/sub
    logic                 v1_reg;
    logic [CMD_W-1:0]     cmd1_reg;
    logic signed [PW-1:0] prr_reg, pii_reg, pri_reg, pir_reg, pbr_reg, pbi_reg;
    logic signed [W:0]    as_re1_reg, as_im1_reg;
    logic signed [W-1:0]  ar, ai, br, bi;
    logic signed [W:0]    as_re_next, as_im_next;

    assign ar = a_re_i;
    assign ai = a_im_i;
    assign br = b_re_i;
    assign bi = b_im_i;

    always_comb begin
        if (cmd_i == CMD_SUB) begin
            as_re_next = (W + 1)'(ar) - (W + 1)'(br);
            as_im_next = (W + 1)'(ai) - (W + 1)'(bi);
        end else begin
            as_re_next = (W + 1)'(ar) + (W + 1)'(br);
            as_im_next = (W + 1)'(ai) + (W + 1)'(bi);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd1_reg   <= cmd_i;
            prr_reg    <= PW'(ar) * PW'(br);
            pii_reg    <= PW'(ai) * PW'(bi);
            pri_reg    <= PW'(ar) * PW'(bi);
            pir_reg    <= PW'(ai) * PW'(br);
            pbr_reg    <= PW'(br) * PW'(br);
            pbi_reg    <= PW'(bi) * PW'(bi);
            as_re1_reg <= as_re_next;
            as_im1_reg <= as_im_next;
        end
    end

    // stage 2: product sums and divisor
    logic                 v2_reg;
    logic [CMD_W-1:0]     cmd2_reg;
    logic signed [SW-1:0] s_re2_reg, s_im2_reg;
    logic [PW-1:0]        den2_reg;
    logic signed [W:0]    as_re2_reg, as_im2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd2_reg <= cmd1_reg;
            if (cmd1_reg == CMD_MUL) begin
                s_re2_reg <= SW'(prr_reg) - SW'(pii_reg);
                s_im2_reg <= SW'(pri_reg) + SW'(pir_reg);
            end else begin
                s_re2_reg <= SW'(prr_reg) + SW'(pii_reg);
                s_im2_reg <= SW'(pir_reg) - SW'(pri_reg);
            end
            den2_reg   <= $unsigned(pbr_reg) + $unsigned(pbi_reg);
            as_re2_reg <= as_re1_reg;
            as_im2_reg <= as_im1_reg;
        end
    end

    // stage 3: scale/clamp for mul and add/sub, dividend setup for div
    function automatic logic [W:0] clamp_w(input logic signed [SW-1:0] v);
        logic [W:0] r;
        if (v > SMAX) begin
            r = {1'b1, SMAX[W-1:0]};
        end else if (v < SMIN) begin
            r = {1'b1, SMIN[W-1:0]};
        end else begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    logic signed [SW-1:0] s_l [2];
    logic signed [SW-1:0] fl_l [2];
    logic [SW-1:0]        mag_l [2];
    logic [NW-1:0]        nn_l [2];
    logic [NW-1:0]        hi_l [2];
    logic [W:0]           cm_l [2];
    logic [W:0]           ca_l [2];
    logic [1:0]           neg_l, over_l;
    logic                 dz;
    ctl_t                 ctl_next;
    logic [1:0][PW-1:0]   rem_next;
    logic [1:0][W-1:0]    lo_next, q_next;

    assign s_l[0] = s_re2_reg;
    assign s_l[1] = s_im2_reg;
    assign ca_l[0] = clamp_w(SW'(as_re2_reg));
    assign ca_l[1] = clamp_w(SW'(as_im2_reg));
    assign dz = (den2_reg == '0);

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            fl_l[l]    = s_l[l] >>> FRAC_BITS;
            cm_l[l]    = clamp_w(fl_l[l]);
            neg_l[l]   = s_l[l][SW-1];
            mag_l[l]   = neg_l[l] ? -s_l[l] : s_l[l];
            nn_l[l]    = NW'(mag_l[l][PW-1:0]) << FRAC_BITS;
            hi_l[l]    = nn_l[l] >> W;
            over_l[l]  = (hi_l[l] >= NW'(den2_reg));
            rem_next[l] = hi_l[l][PW-1:0];
            lo_next[l]  = nn_l[l][W-1:0];
        end
        ctl_next.valid  = v2_reg;
        ctl_next.is_div = (cmd2_reg == CMD_DIV) && !dz;
        ctl_next.neg    = neg_l;
        ctl_next.over   = over_l;
        case (cmd2_reg)
            CMD_ADD, CMD_SUB: begin
                ctl_next.status = (ca_l[0][W] || ca_l[1][W]) ? ST_SAT : ST_OK;
                q_next[0] = ca_l[0][W-1:0];
                q_next[1] = ca_l[1][W-1:0];
            end
            CMD_MUL: begin
                ctl_next.status = (cm_l[0][W] || cm_l[1][W]) ? ST_SAT : ST_OK;
                q_next[0] = cm_l[0][W-1:0];
                q_next[1] = cm_l[1][W-1:0];
            end
            default: begin
                ctl_next.status = dz ? ST_DZ : ST_OK;
                q_next[0] = '0;
                q_next[1] = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_o <= '0;
        end else if (en) begin
            ctl_o <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_o <= den2_reg;
            rem_o <= rem_next;
            lo_o  <= lo_next;
            q_o   <= q_next;
        end
    end

endmodule

/* rtl/cau_div_step.sv */
module cau_div_step #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  cau_pkg::ctl_t                ctl_i,
    input  logic [2*DATA_WIDTH-1:0]      den_i,
    input  logic [1:0][2*DATA_WIDTH-1:0] rem_i,
    input  logic [1:0][DATA_WIDTH-1:0]   lo_i,
    input  logic [1:0][DATA_WIDTH-1:0]   q_i,
    output cau_pkg::ctl_t                ctl_o,
    output logic [2*DATA_WIDTH-1:0]      den_o,
    output logic [1:0][2*DATA_WIDTH-1:0] rem_o,
    output logic [1:0][DATA_WIDTH-1:0]   lo_o,
    output logic [1:0][DATA_WIDTH-1:0]   q_o
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;

    logic [PW-1:0]      sh [2];
    logic [1:0]         ge;
    logic [1:0][PW-1:0] rem_next;
    logic [1:0][W-1:0]  lo_next, q_next;

    // one restoring-division bit per lane; remainder stays below den while the lane's over flag is clear
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            sh[l]       = {rem_i[l][PW-2:0], lo_i[l][W-1]};
            ge[l]       = (sh[l] >= den_i);
            rem_next[l] = ge[l] ? sh[l] - den_i : sh[l];
            lo_next[l]  = {lo_i[l][W-2:0], 1'b0};
            q_next[l]   = ctl_i.is_div ? {q_i[l][W-2:0], ge[l]} : q_i[l];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_o <= '0;
        end else if (en) begin
            ctl_o <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_o <= den_i;
            rem_o <= rem_next;
            lo_o  <= lo_next;
            q_o   <= q_next;
        end
    end

endmodule

/* rtl/complex_arithmetic_unit.sv */
// Complex add / subtract / multiply / divide on signed Q-format operands.
// Input stream: s_tuser carries the command (0 add, 1 sub, 2 mul, 3 div),
// s_tdata carries a_re, a_im, b_re, b_im. Output stream: m_tdata carries
// result_re, result_im; m_tuser carries status (0 ok, 1 div by zero, 2 sat).
// Only the low DATA_WIDTH bits of each operand are used; results are
// sign-extended to 32 bits.
// Every command runs through the same pipeline: multiply, sum, scale, one
// stage per quotient bit of the restoring divider, output register. It takes
// one request per cycle while the output is not stalled.
// The divider chain (one compare/subtract per stage) sets the depth.
// Reset empties the pipeline and drops m_tvalid. When the receiver holds
// m_tready low with a result waiting, the whole pipeline freezes and
// s_tready goes low; nothing is lost or repeated.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // a_re[31:0], a_im[63:32], b_re[95:64], b_im[127:96]
    input  logic [1:0]   s_tuser,  // command[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,  // result_re[31:0], result_im[63:32]
    output logic [1:0]   m_tuser   // status[1:0]
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;

    logic en;
    logic m_tvalid_reg;
    logic [2*FIELD_W-1:0] m_tdata_reg;
    logic [ST_W-1:0] m_tuser_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    ctl_t               ctl_c [W+1];
    logic [PW-1:0]      den_c [W+1];
    logic [1:0][PW-1:0] rem_c [W+1];
    logic [1:0][W-1:0]  lo_c  [W+1];
    logic [1:0][W-1:0]  q_c   [W+1];

    cau_front #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_valid(s_tvalid),
        .cmd_i   (s_tuser),
        .a_re_i  (s_tdata[0*FIELD_W +: W]),
        .a_im_i  (s_tdata[1*FIELD_W +: W]),
        .b_re_i  (s_tdata[2*FIELD_W +: W]),
        .b_im_i  (s_tdata[3*FIELD_W +: W]),
        .ctl_o   (ctl_c[0]),
        .den_o   (den_c[0]),
        .rem_o   (rem_c[0]),
        .lo_o    (lo_c[0]),
        .q_o     (q_c[0])
    );

    for (genvar k = 0; k < W; k++) begin : g_div
        cau_div_step #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_step (
            .aclk   (aclk),
            .aresetn(aresetn),
            .en     (en),
            .ctl_i  (ctl_c[k]),
            .den_i  (den_c[k]),
            .rem_i  (rem_c[k]),
            .lo_i   (lo_c[k]),
            .q_i    (q_c[k]),
            .ctl_o  (ctl_c[k+1]),
            .den_o  (den_c[k+1]),
            .rem_o  (rem_c[k+1]),
            .lo_o   (lo_c[k+1]),
            .q_o    (q_c[k+1])
        );
    end

    // final quotient sign and clamp
    ctl_t                ctl_f;
    logic [W-1:0]        qf [2];
    logic signed [W-1:0] val [2];
    logic [1:0]          sat;
    logic [ST_W-1:0]     status_next;

    assign ctl_f = ctl_c[W];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            qf[l]  = q_c[W][l];
            sat[l] = 1'b0;
            val[l] = qf[l];
            if (ctl_f.is_div) begin
                if (ctl_f.over[l]) begin
                    sat[l] = 1'b1;
                    val[l] = ctl_f.neg[l] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
                end else if (ctl_f.neg[l]) begin
                    if (qf[l][W-1] && (|qf[l][W-2:0])) begin
                        sat[l] = 1'b1;
                        val[l] = {1'b1, {(W - 1){1'b0}}};
                    end else begin
                        val[l] = -qf[l];
                    end
                end else if (qf[l][W-1]) begin
                    sat[l] = 1'b1;
                    val[l] = {1'b0, {(W - 1){1'b1}}};
                end
            end
        end
        if (ctl_f.is_div) begin
            status_next = (|sat) ? ST_SAT : ST_OK;
        end else begin
            status_next = ctl_f.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= ctl_f.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {FIELD_W'(val[1]), FIELD_W'(val[0])};
            m_tuser_reg <= status_next;
        end
    end

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_DZ) |-> (m_tdata == '0))
        else $error("divide-by-zero result not zero");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_DZ || m_tuser == ST_SAT))
        else $error("bad status code");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_stall_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

endmodule

/* bench/tb.sv */
module tb;
    import cau_pkg::*;

    typedef struct packed {
        logic [31:0]     re;
        logic [31:0]     im;
        logic [ST_W-1:0] status;
    } cplx_res_t;

    localparam logic [31:0] WMAX = 32'h7fffffff;
    localparam logic [31:0] WMIN = 32'h80000000;
    localparam int FRAC_SHIFT = 16;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;

    cplx_res_t pending_results[$];
    int        fails = 0;
    int        ready_pct = 100;

    complex_arithmetic_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout bit sat);
        if (v > $signed({96'd0, WMAX})) begin
            sat = 1'b1;
            return WMAX;
        end
        if (v < -$signed(128'sh80000000)) begin
            sat = 1'b1;
            return WMIN;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [127:0] quot(input logic signed [127:0] num,
                                                 input logic [127:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (num < 0) ? -num : num;
        q = (mag << FRAC_SHIFT) / den;
        return (num < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic cplx_res_t cplx_eval(input logic [1:0] cmd,
                                            input logic signed [31:0] ar, ai, br, bi);
        cplx_res_t r;
        logic signed [127:0] x, y, den;
        bit sat;
        sat = 1'b0;
        r = '0;
        case (cmd)
            CMD_ADD: begin
                x = ar; x = x + br;
                y = ai; y = y + bi;
            end
            CMD_SUB: begin
                x = ar; x = x - br;
                y = ai; y = y - bi;
            end
            CMD_MUL: begin
                x = ar; x = (x * br - 128'(ai) * 128'(bi));
                y = ar; y = (y * bi + 128'(ai) * 128'(br));
                x = x >>> FRAC_SHIFT;
                y = y >>> FRAC_SHIFT;
            end
            default: begin
                x = 128'(ar) * 128'(br) + 128'(ai) * 128'(bi);
                y = 128'(ai) * 128'(br) - 128'(ar) * 128'(bi);
            end
        endcase
        if (cmd == CMD_DIV) begin
            den = 128'(br) * 128'(br) + 128'(bi) * 128'(bi);
            if (den == 0) begin
                r.status = ST_DZ;
                return r;
            end
            x = quot(x, den);
            y = quot(y, den);
        end
        r.re = clamp32(x, sat);
        r.im = clamp32(y, sat);
        r.status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        fails++;
    endtask

    // result checker
    always @(posedge aclk) begin
        cplx_res_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report("unexpected result", m_tdata[31:0], 32'd0);
            end else begin
                w = pending_results.pop_front();
                if (m_tdata[31:0] !== w.re) report("result_re", m_tdata[31:0], w.re);
                if (m_tdata[63:32] !== w.im) report("result_im", m_tdata[63:32], w.im);
                if (m_tuser !== w.status) report("status", 32'(m_tuser), 32'(w.status));
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) < ready_pct);
    end

    // sends one request; valid stays high until the caller idles
    task automatic send_op(input logic [1:0] cmd, input logic [31:0] ar, ai, br, bi);
        @(negedge aclk);
        s_tdata = {bi, br, ai, ar};
        s_tuser = cmd;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(cplx_eval(cmd, ar, ai, br, bi));
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    task automatic drain();
        idle_cycles(1);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (45) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return $urandom_range(0, 32'h40000) - 32'h20000;
            3: return $urandom_range(0, 32'h800) - 32'h400;
            4: begin
                case ($urandom_range(0, 5))
                    0: return WMAX;
                    1: return WMIN;
                    2: return 32'd0;
                    3: return 32'h00010000;
                    4: return 32'hffffffff;
                    default: return 32'hffff0000;
                endcase
            end
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic test_directed();
        logic [1:0] c;
        ready_pct = 100;
        for (int k = 0; k < 4; k++) begin
            c = k[1:0];
            send_op(c, WMAX, WMAX, WMAX, WMAX);
            send_op(c, WMIN, WMIN, WMIN, WMIN);
            send_op(c, WMAX, WMIN, WMIN, WMAX);
            send_op(c, 32'h00010000, 32'hfffe0000, 32'h00030000, 32'h00008000);
        end
        send_op(CMD_DIV, 32'h00050000, 32'h12345678, 32'd0, 32'd0);          // zero divisor
        send_op(CMD_DIV, WMAX, WMAX, 32'd1, 32'd0);                           // divide saturates
        send_op(CMD_DIV, 32'hffffffff, 32'd0, 32'h00030000, 32'd0);           // truncate toward zero
        send_op(CMD_DIV, 32'hfffffffd, 32'd1, 32'h7fff0000, 32'h7fff0000);    // tiny quotient
        send_op(CMD_MUL, 32'hffffffff, 32'd0, 32'd1, 32'd0);                  // floor of negative
        send_op(CMD_MUL, 32'h01000000, 32'd0, 32'h01000000, 32'd0);           // multiply saturates
        send_op(CMD_ADD, WMAX, WMIN, 32'd1, 32'hffffffff);
        send_op(CMD_SUB, WMIN, WMAX, 32'd1, 32'hffffffff);
        drain();
    endtask

    task automatic test_random(input int n);
        int sent, burst;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) == 0) ready_pct = $urandom_range(0, 3) == 0 ? 100
                                                      : $urandom_range(20, 95);
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                send_op(2'($urandom_range(0, 3)), pick_word(), pick_word(), pick_word(),
                        pick_word());
                sent++;
            end
            if (sent % 400 < burst) drain();
            else if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
        end
        drain();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_random(1600);
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end
endmodule

/* filelist.f */
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div_step.sv
rtl/complex_arithmetic_unit.sv
bench/tb.sv
